/* sv/mjm_pkg.sv */
`default_nettype none

package mjm_pkg;

    // Event codes carried on the action field
    typedef enum logic [2:0] {
        ACT_X_AXIS       = 3'd0,
        ACT_Y_AXIS       = 3'd1,
        ACT_OTHER_AXIS   = 3'd2,
        ACT_LEFT_ROTATE  = 3'd3,
        ACT_RIGHT_ROTATE = 3'd4,
        ACT_OTHER_KEY    = 3'd5,
        ACT_OTHER_EVENT  = 3'd6
    } action_t;

    // Rotate modes
    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_LEFT  = 2'd1,
        MODE_RIGHT = 2'd2
    } mode_t;

    localparam int unsigned ACTION_W = 3;
    localparam int unsigned VALUE_W  = 8;
    localparam int unsigned DUTY_W   = 7;

    localparam logic [DUTY_W-1:0]  OFFSET_RESET   = 7'd50;
    localparam logic [VALUE_W-1:0] AXIS_RESET     = 8'd127;
    localparam logic [VALUE_W-1:0] BUTTON_PRESSED = 8'd1;

    // One input word held in the input register
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [VALUE_W-1:0]  value;
    } item_t;

    // Direction and duty of one wheel
    typedef struct packed {
        logic              forward;
        logic [DUTY_W-1:0] duty;
    } wheel_t;

endpackage

`default_nettype wire

/* sv/mjm_in_reg.sv */
`default_nettype none

module mjm_in_reg
    import mjm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [ACTION_W-1:0] action,
    input  wire logic [VALUE_W-1:0]  event_value,
    output logic                     item_valid,
    output item_t                    item,
    input  wire logic                item_take
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Accept a new word when the register is empty or drains this cycle
    assign in_ready = !valid_reg || item_take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    // Hold the control bit under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on accept
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.action <= action;
            item_reg.value  <= event_value;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

/* sv/mjm_mix.sv */
`default_nettype none

module mjm_mix
    import mjm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write_en,
    input  wire logic [DUTY_W-1:0] cfg_write_data,
    input  wire logic              item_valid,
    input  wire item_t             item,
    output logic                   item_take,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output wheel_t                 lf_wheel,
    output wheel_t                 rf_wheel,
    output wheel_t                 lr_wheel,
    output wheel_t                 rr_wheel
);

    // Map an axis position 0..255 to v*200/255 - 100
    function automatic logic signed [9:0] scale_axis(input logic [VALUE_W-1:0] v);
        logic [15:0] p;
        logic [15:0] q;
        begin
            p = ({8'b0, v} << 7) + ({8'b0, v} << 6) + ({8'b0, v} << 3);
            q = (p + (p >> 8) + 16'd1) >> 8;
            scale_axis = $signed({2'b00, q[7:0]}) - 10'sd100;
        end
    endfunction

    // Clamp to -100..100 and split into direction and duty
    function automatic wheel_t clamp_wheel(input logic signed [9:0] s);
        logic signed [9:0] c;
        logic        [9:0] m;
        wheel_t            w;
        begin
            if (s > 10'sd100)
            begin
                c = 10'sd100;
            end
            else if (s < -10'sd100)
            begin
                c = -10'sd100;
            end
            else
            begin
                c = s;
            end
            m         = c[9] ? 10'(-c) : 10'(c);
            w.forward = !c[9];
            w.duty    = m[DUTY_W-1:0];
            clamp_wheel = w;
        end
    endfunction

    logic [VALUE_W-1:0] x_reg;
    logic [VALUE_W-1:0] x_next;
    logic [VALUE_W-1:0] y_reg;
    logic [VALUE_W-1:0] y_next;
    mode_t              mode_reg;
    mode_t              mode_next;
    logic [DUTY_W-1:0]  offset_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    wheel_t             lf_reg;
    wheel_t             rf_reg;
    wheel_t             lr_reg;
    wheel_t             rr_reg;

    logic               produce;
    logic signed [9:0]  xs;
    logic signed [9:0]  ys;
    logic signed [9:0]  off;
    logic signed [9:0]  lf_s;
    logic signed [9:0]  rf_s;
    logic signed [9:0]  lr_s;
    logic signed [9:0]  rr_s;

    // Decode the event into the state it leaves
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        mode_next = mode_reg;
        produce   = 1'b1;
        case (item.action)
            ACT_X_AXIS:
            begin
                x_next = item.value;
            end
            ACT_Y_AXIS:
            begin
                y_next = item.value;
            end
            ACT_LEFT_ROTATE:
            begin
                mode_next = (item.value == BUTTON_PRESSED) ? MODE_LEFT : MODE_NONE;
            end
            ACT_RIGHT_ROTATE:
            begin
                mode_next = (item.value == BUTTON_PRESSED) ? MODE_RIGHT : MODE_NONE;
            end
            ACT_OTHER_AXIS, ACT_OTHER_KEY:
            begin
                produce = 1'b1;
            end
            default:
            begin
                produce = 1'b0;
            end
        endcase
    end

    // Advance when the word makes no result or the result register has room
    assign item_take = item_valid && (!produce || !out_valid_reg || out_ready);

    // Mix the updated axes into four wheel speeds, adding or subtracting the rotate offset in a rotate mode
    always_comb
    begin
        xs   = scale_axis(x_next);
        ys   = -scale_axis(y_next);
        off  = $signed({3'b000, offset_reg});
        lf_s = ys + xs;
        rf_s = ys - xs;
        lr_s = ys - xs;
        rr_s = ys + xs;
        case (mode_next)
            MODE_LEFT:
            begin
                lf_s = ys + xs - off;
                rf_s = ys - xs + off;
                lr_s = ys - xs - off;
                rr_s = ys + xs + off;
            end
            MODE_RIGHT:
            begin
                lf_s = ys + xs + off;
                rf_s = ys - xs - off;
                lr_s = ys - xs + off;
                rr_s = ys + xs - off;
            end
            default:
            begin
                lf_s = ys + xs;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (item_take && produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold state, offset and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg         <= AXIS_RESET;
            y_reg         <= AXIS_RESET;
            mode_reg      <= MODE_NONE;
            offset_reg    <= OFFSET_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                offset_reg <= cfg_write_data;
            end
            if (item_take)
            begin
                x_reg    <= x_next;
                y_reg    <= y_next;
                mode_reg <= mode_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (item_take && produce)
        begin
            lf_reg <= clamp_wheel(lf_s);
            rf_reg <= clamp_wheel(rf_s);
            lr_reg <= clamp_wheel(lr_s);
            rr_reg <= clamp_wheel(rr_s);
        end
    end

    assign out_valid = out_valid_reg;
    assign lf_wheel  = lf_reg;
    assign rf_wheel  = rf_reg;
    assign lr_wheel  = lr_reg;
    assign rr_wheel  = rr_reg;

endmodule

`default_nettype wire

/* sv/mecanum_joystick_motor_mixer_top.sv */
// Channel   Handshake              Word
// input     in_valid / in_ready    action, event_value
// output    out_valid / out_ready  {left,right}_{front,rear}_{forward,duty}
// config    cfg_write_en           cfg_write_data (rotate offset)
//
// One word is accepted per cycle while in_ready is high; it is held in the
// input register, and its result is then loaded into the result register,
// where out_valid rises. The path between them is a constant scaling of each
// axis, a 10-bit add and a clamp per wheel. Reset restores axes to 127, no
// rotation, offset 50. A stalled result holds its register; the input register
// keeps taking words that make no result.
`default_nettype none

module mecanum_joystick_motor_mixer_top
    import mjm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write_en,
    input  wire logic [DUTY_W-1:0]   cfg_write_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [ACTION_W-1:0] action,
    input  wire logic [VALUE_W-1:0]  event_value,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     left_front_forward,
    output logic [DUTY_W-1:0]        left_front_duty,
    output logic                     right_front_forward,
    output logic [DUTY_W-1:0]        right_front_duty,
    output logic                     left_rear_forward,
    output logic [DUTY_W-1:0]        left_rear_duty,
    output logic                     right_rear_forward,
    output logic [DUTY_W-1:0]        right_rear_duty
);

    logic   item_valid;
    item_t  item;
    logic   item_take;
    wheel_t lf_wheel;
    wheel_t rf_wheel;
    wheel_t lr_wheel;
    wheel_t rr_wheel;

    mjm_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .event_value (event_value),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take)
    );

    mjm_mix u_mix (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .item_valid     (item_valid),
        .item           (item),
        .item_take      (item_take),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .lf_wheel       (lf_wheel),
        .rf_wheel       (rf_wheel),
        .lr_wheel       (lr_wheel),
        .rr_wheel       (rr_wheel)
    );

    assign left_front_forward  = lf_wheel.forward;
    assign left_front_duty     = lf_wheel.duty;
    assign right_front_forward = rf_wheel.forward;
    assign right_front_duty    = rf_wheel.duty;
    assign left_rear_forward   = lr_wheel.forward;
    assign left_rear_duty      = lr_wheel.duty;
    assign right_rear_forward  = rr_wheel.forward;
    assign right_rear_duty     = rr_wheel.duty;

endmodule

`default_nettype wire

/* sv/mjm_checker.sv */
`default_nettype none

module mjm_checker
    import mjm_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic              left_front_forward,
    input wire logic [DUTY_W-1:0] left_front_duty,
    input wire logic              right_front_forward,
    input wire logic [DUTY_W-1:0] right_front_duty,
    input wire logic              left_rear_forward,
    input wire logic [DUTY_W-1:0] left_rear_duty,
    input wire logic              right_rear_forward,
    input wire logic [DUTY_W-1:0] right_rear_duty
);

    // Keep a stalled result word offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // Keep a stalled result word unchanged
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(left_front_duty) && $stable(right_front_duty) &&
            $stable(left_rear_duty) && $stable(right_rear_duty) &&
            $stable(left_front_forward) && $stable(right_front_forward) &&
            $stable(left_rear_forward) && $stable(right_rear_forward))
        else $error("result word changed while stalled");

    // Duties never pass the clamp
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> left_front_duty <= 7'd100 && right_front_duty <= 7'd100 &&
            left_rear_duty <= 7'd100 && right_rear_duty <= 7'd100)
        else $error("duty above 100");

    // A stopped wheel reads as forward
    a_zero_forward: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (left_front_duty != 7'd0 || left_front_forward) &&
            (right_front_duty != 7'd0 || right_front_forward) &&
            (left_rear_duty != 7'd0 || left_rear_forward) &&
            (right_rear_duty != 7'd0 || right_rear_forward))
        else $error("zero duty shown as reverse");

endmodule

bind mecanum_joystick_motor_mixer_top mjm_checker u_mjm_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .left_front_forward  (left_front_forward),
    .left_front_duty     (left_front_duty),
    .right_front_forward (right_front_forward),
    .right_front_duty    (right_front_duty),
    .left_rear_forward   (left_rear_forward),
    .left_rear_duty      (left_rear_duty),
    .right_rear_forward  (right_rear_forward),
    .right_rear_duty     (right_rear_duty)
);

`default_nettype wire

/* bench/mixer_checker.sv */
`timescale 1ns / 100ps

module mixer_checker
    import mjm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write_en,
    input  wire logic [DUTY_W-1:0]   cfg_write_data,
    input  wire logic                in_valid,
    input  wire logic                in_ready,
    input  wire logic [ACTION_W-1:0] action,
    input  wire logic [VALUE_W-1:0]  event_value,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire logic                left_front_forward,
    input  wire logic [DUTY_W-1:0]   left_front_duty,
    input  wire logic                right_front_forward,
    input  wire logic [DUTY_W-1:0]   right_front_duty,
    input  wire logic                left_rear_forward,
    input  wire logic [DUTY_W-1:0]   left_rear_duty,
    input  wire logic                right_rear_forward,
    input  wire logic [DUTY_W-1:0]   right_rear_duty,
    output int                       mismatch_count,
    output int                       words_pending
);

    // Signed wheel speed wide enough for mix plus offset before the clamp
    typedef logic signed [10:0] speed_t;

    typedef struct packed {
        wheel_t lf;
        wheel_t rf;
        wheel_t lr;
        wheel_t rr;
    } drive_t;

    logic [VALUE_W-1:0] x_pos;
    logic [VALUE_W-1:0] y_pos;
    mode_t              rot_mode;
    logic [DUTY_W-1:0]  rot_offset;
    drive_t             drive_q[$];

    // Clamp a speed to +/-100 and split it into direction and duty
    function automatic wheel_t to_wheel(input speed_t s);
        speed_t c;
        speed_t mag;
        wheel_t w;
        if (s > 11'sd100)
            c = 11'sd100;
        else if (s < -11'sd100)
            c = -11'sd100;
        else
            c = s;
        mag = (c < 0) ? -c : c;
        w.forward = (c >= 0);
        w.duty = mag[DUTY_W-1:0];
        return w;
    endfunction

    // Scale both axes, mix into four wheels and apply the rotate offset
    function automatic drive_t mix_wheels(input logic [VALUE_W-1:0] x,
                                          input logic [VALUE_W-1:0] y,
                                          input mode_t m,
                                          input logic [DUTY_W-1:0] off);
        logic [15:0] x_scaled;
        logic [15:0] y_scaled;
        speed_t xs;
        speed_t ys;
        speed_t rot;
        speed_t fwd_mix;
        speed_t cross_mix;
        drive_t d;
        x_scaled = ({8'd0, x} * 16'd200) / 16'd255;
        y_scaled = ({8'd0, y} * 16'd200) / 16'd255;
        xs = $signed(x_scaled[10:0]) - 11'sd100;
        ys = 11'sd100 - $signed(y_scaled[10:0]);
        fwd_mix = ys + xs;
        cross_mix = ys - xs;
        case (m)
            MODE_LEFT:  rot = $signed({4'b0000, off});
            MODE_RIGHT: rot = -$signed({4'b0000, off});
            default:    rot = 11'sd0;
        endcase
        d.lf = to_wheel(fwd_mix - rot);
        d.rf = to_wheel(cross_mix + rot);
        d.lr = to_wheel(cross_mix - rot);
        d.rr = to_wheel(fwd_mix + rot);
        return d;
    endfunction

    task automatic check_wheel(input string name, input wheel_t exp, input wheel_t got);
        if (exp.forward !== got.forward)
        begin
            $display("%0t: %s forward expected %0d actual %0d",
                     $time, name, exp.forward, got.forward);
            mismatch_count++;
        end
        if (exp.duty !== got.duty)
        begin
            $display("%0t: %s duty expected %0d actual %0d",
                     $time, name, exp.duty, got.duty);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        drive_t exp;
        drive_t got;
        bit     makes_result;
        if (!rst_n)
        begin
            x_pos = AXIS_RESET;
            y_pos = AXIS_RESET;
            rot_mode = MODE_NONE;
            rot_offset = OFFSET_RESET;
            drive_q.delete();
            words_pending = 0;
            mismatch_count = 0;
        end
        else
        begin
            // Track the offset register
            if (cfg_write_en)
                rot_offset = cfg_write_data;

            // Compare each delivered word with the oldest prediction
            if (out_valid && out_ready)
            begin
                got.lf = {left_front_forward, left_front_duty};
                got.rf = {right_front_forward, right_front_duty};
                got.lr = {left_rear_forward, left_rear_duty};
                got.rr = {right_rear_forward, right_rear_duty};
                if (drive_q.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none actual %h",
                             $time, got);
                    mismatch_count++;
                end
                else
                begin
                    exp = drive_q.pop_front();
                    check_wheel("left_front", exp.lf, got.lf);
                    check_wheel("right_front", exp.rf, got.rf);
                    check_wheel("left_rear", exp.lr, got.lr);
                    check_wheel("right_rear", exp.rr, got.rr);
                end
            end

            // Advance the state on each accepted event word
            if (in_valid && in_ready)
            begin
                makes_result = 1'b1;
                case (action)
                    ACT_X_AXIS:       x_pos = event_value;
                    ACT_Y_AXIS:       y_pos = event_value;
                    ACT_OTHER_AXIS:   ;
                    ACT_LEFT_ROTATE:
                        rot_mode = (event_value == BUTTON_PRESSED) ? MODE_LEFT : MODE_NONE;
                    ACT_RIGHT_ROTATE:
                        rot_mode = (event_value == BUTTON_PRESSED) ? MODE_RIGHT : MODE_NONE;
                    ACT_OTHER_KEY:    ;
                    default:          makes_result = 1'b0;
                endcase
                if (makes_result)
                    drive_q.push_back(mix_wheels(x_pos, y_pos, rot_mode, rot_offset));
            end
            words_pending = drive_q.size();
        end
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
    import mjm_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
    localparam int RANDOM_WORDS = 140;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 400000;

    logic                clk;
    logic                rst_n;
    logic                cfg_write_en;
    logic [DUTY_W-1:0]   cfg_write_data;
    logic                in_valid;
    logic                in_ready;
    logic [ACTION_W-1:0] action;
    logic [VALUE_W-1:0]  event_value;
    logic                out_valid;
    logic                out_ready;
    logic                left_front_forward;
    logic [DUTY_W-1:0]   left_front_duty;
    logic                right_front_forward;
    logic [DUTY_W-1:0]   right_front_duty;
    logic                left_rear_forward;
    logic [DUTY_W-1:0]   left_rear_duty;
    logic                right_rear_forward;
    logic [DUTY_W-1:0]   right_rear_duty;
    int                  mismatch_count;
    int                  words_pending;
    bit                  idle_on;
    int                  cycle_count = 0;

    mecanum_joystick_motor_mixer_top dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write_en        (cfg_write_en),
        .cfg_write_data      (cfg_write_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .action              (action),
        .event_value         (event_value),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .left_front_forward  (left_front_forward),
        .left_front_duty     (left_front_duty),
        .right_front_forward (right_front_forward),
        .right_front_duty    (right_front_duty),
        .left_rear_forward   (left_rear_forward),
        .left_rear_duty      (left_rear_duty),
        .right_rear_forward  (right_rear_forward),
        .right_rear_duty     (right_rear_duty)
    );

    mixer_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write_en        (cfg_write_en),
        .cfg_write_data      (cfg_write_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .action              (action),
        .event_value         (event_value),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .left_front_forward  (left_front_forward),
        .left_front_duty     (left_front_duty),
        .right_front_forward (right_front_forward),
        .right_front_duty    (right_front_duty),
        .left_rear_forward   (left_rear_forward),
        .left_rear_duty      (left_rear_duty),
        .right_rear_forward  (right_rear_forward),
        .right_rear_duty     (right_rear_duty),
        .mismatch_count      (mismatch_count),
        .words_pending       (words_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("mecanum_joystick_motor_mixer_top verification failed");
            $finish;
        end
    end

    // Stall the result side in random bursts
    initial
    begin
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // Present one event word, hold it until taken, then maybe go idle
    task automatic send_word(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val);
        action <= act;
        event_value <= val;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
    endtask

    // Drain the pipe, then write a new rotate offset
    task automatic write_offset(input logic [DUTY_W-1:0] off);
        in_valid <= 1'b0;
        while (words_pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= off;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Mostly axis motion and button presses, with some stray events
    task automatic run_random(input int count, input bit allow_idle);
        logic [ACTION_W-1:0] act;
        logic [VALUE_W-1:0]  val;
        int                  pick;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 30)
                act = ACT_X_AXIS;
            else if (pick < 60)
                act = ACT_Y_AXIS;
            else if (pick < 67)
                act = ACT_OTHER_AXIS;
            else if (pick < 78)
                act = ACT_LEFT_ROTATE;
            else if (pick < 89)
                act = ACT_RIGHT_ROTATE;
            else if (pick < 94)
                act = ACT_OTHER_KEY;
            else if (pick < 97)
                act = ACT_OTHER_EVENT;
            else
                act = ACT_UNUSED;
            if ((act == ACT_LEFT_ROTATE || act == ACT_RIGHT_ROTATE) && $urandom_range(0, 1))
                val = BUTTON_PRESSED;
            else if ($urandom_range(0, 9) == 0)
                val = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            else
                val = 8'($urandom_range(0, 255));
            send_word(act, val);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = '0;
        in_valid = 1'b0;
        action = ACT_OTHER_EVENT;
        event_value = '0;
        idle_on = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset state, axis extremes, button presses and releases
        idle_on = 1'b1;
        send_word(ACT_OTHER_KEY, 8'd0);
        send_word(ACT_X_AXIS, 8'd0);
        send_word(ACT_Y_AXIS, 8'd0);
        send_word(ACT_X_AXIS, 8'd255);
        send_word(ACT_Y_AXIS, 8'd255);
        send_word(ACT_OTHER_AXIS, 8'd200);
        send_word(ACT_LEFT_ROTATE, BUTTON_PRESSED);
        send_word(ACT_X_AXIS, 8'd0);
        send_word(ACT_OTHER_KEY, 8'd1);
        send_word(ACT_LEFT_ROTATE, 8'd0);
        send_word(ACT_RIGHT_ROTATE, BUTTON_PRESSED);
        send_word(ACT_Y_AXIS, 8'd0);
        send_word(ACT_LEFT_ROTATE, BUTTON_PRESSED);
        send_word(ACT_RIGHT_ROTATE, 8'd2);
        send_word(ACT_RIGHT_ROTATE, BUTTON_PRESSED);
        send_word(ACT_LEFT_ROTATE, 8'd255);
        send_word(ACT_OTHER_EVENT, 8'd1);
        send_word(ACT_UNUSED, 8'd255);
        send_word(ACT_RIGHT_ROTATE, 8'd255);
        send_word(ACT_X_AXIS, 8'd128);

        write_offset(7'd100);
        run_random(RANDOM_WORDS, 1'b1);

        write_offset(7'd0);
        run_random(RANDOM_WORDS, 1'b1);

        // Largest offset with both rotations at full stick
        write_offset(7'd127);
        idle_on = 1'b1;
        send_word(ACT_LEFT_ROTATE, BUTTON_PRESSED);
        send_word(ACT_X_AXIS, 8'd0);
        send_word(ACT_Y_AXIS, 8'd255);
        send_word(ACT_RIGHT_ROTATE, BUTTON_PRESSED);
        send_word(ACT_X_AXIS, 8'd255);
        run_random(RANDOM_WORDS, 1'b1);

        write_offset(7'($urandom_range(1, 99)));
        run_random(RANDOM_WORDS, 1'b1);

        write_offset(7'($urandom_range(0, 127)));
        run_random(RANDOM_WORDS, 1'b1);

        // Last stretch at full rate on both sides
        write_offset(7'($urandom_range(0, 100)));
        run_random(RANDOM_WORDS, 1'b0);
        idle_on = 1'b0;

        in_valid <= 1'b0;
        while (words_pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("mecanum_joystick_motor_mixer_top verification clean");
        else
            $display("mecanum_joystick_motor_mixer_top verification failed");
        $finish;
    end

endmodule

/* filelist.f */
sv/mjm_pkg.sv
sv/mjm_in_reg.sv
sv/mjm_mix.sv
sv/mecanum_joystick_motor_mixer_top.sv
sv/mjm_checker.sv
bench/mixer_checker.sv
bench/tb.sv
